// ===== rtl/utf8_text_width_measure_defines.svh =====
// Assertion macros used by the top RTL file of the text width measurer.
`ifndef UTF8_TEXT_WIDTH_MEASURE_DEFINES_SVH
`define UTF8_TEXT_WIDTH_MEASURE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UTFW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define UTFW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/utfw_pkg.sv =====
package utfw_pkg;

    localparam int GLYPH_SLOTS = 256;
    localparam int CELL_SLOTS  = 8;
    localparam int CELL_SEL_W  = $clog2(CELL_SLOTS);
    localparam int CELLS       = (GLYPH_SLOTS + CELL_SLOTS - 1) / CELL_SLOTS;

    localparam int CODE_W   = 21;
    localparam int ADV_W    = 8;
    localparam int SLOT_W   = 8;
    localparam int BYTE_W   = 8;
    localparam int WIDTH_W  = 24;
    localparam int GCOUNT_W = 9;
    localparam int CELLW_W  = 8;
    localparam int PEND_W   = 2;

    // Remaining-slot counter carried along the cell row; at least wide
    // enough to compare against the slot count of one cell.
    localparam int LEFT_RAW = $clog2(GLYPH_SLOTS + 1);
    localparam int LEFT_W   = (LEFT_RAW > CELL_SEL_W + 1) ? LEFT_RAW : CELL_SEL_W + 1;
    localparam int CMP_W    = (LEFT_W > GCOUNT_W) ? LEFT_W : GCOUNT_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH  = 2'd1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEXT = 1'b1;

    localparam logic [BYTE_W-1:0] UTF_ASCII_LIM = 8'h80;
    localparam logic [BYTE_W-1:0] UTF_MASK_2    = 8'hE0;
    localparam logic [BYTE_W-1:0] UTF_LEAD_2    = 8'hC0;
    localparam logic [BYTE_W-1:0] UTF_MASK_3    = 8'hF0;
    localparam logic [BYTE_W-1:0] UTF_LEAD_3    = 8'hE0;
    localparam logic [BYTE_W-1:0] UTF_MASK_4    = 8'hF8;
    localparam logic [BYTE_W-1:0] UTF_LEAD_4    = 8'hF0;
    localparam logic [BYTE_W-1:0] UTF_BITS_CONT = 8'h3F;
    localparam logic [BYTE_W-1:0] UTF_BITS_2    = 8'h1F;
    localparam logic [BYTE_W-1:0] UTF_BITS_3    = 8'h0F;
    localparam logic [BYTE_W-1:0] UTF_BITS_4    = 8'h07;
    localparam logic [CODE_W-1:0] CP_QMARK      = 21'h00003F;

    localparam logic [WIDTH_W-1:0] WIDTH_MAX = {WIDTH_W{1'b1}};

    typedef struct packed {
        logic                op;
        logic [SLOT_W-1:0]   slot;
        logic [CODE_W-1:0]   glyph_code;
        logic [ADV_W-1:0]    glyph_advance;
        logic [BYTE_W-1:0]   text_byte;
        logic                last;
    } t_in_item;

    typedef struct packed {
        logic [WIDTH_W-1:0] total_width;
        logic               ended_by_zero;
    } t_out_item;

    // One probe travelling down the cell row: either a slot write or a
    // codepoint search.
    typedef struct packed {
        logic               valid;
        logic               is_load;
        logic               found;
        logic [LEFT_W-1:0]  left;
        logic [CODE_W-1:0]  code;
        logic [ADV_W-1:0]   adv;
    } t_probe;

    // Decoder verdict for one text byte.
    typedef struct packed {
        logic               done;
        logic [CODE_W-1:0]  cp;
        logic [PEND_W-1:0]  pending;
        logic [CODE_W-1:0]  partial;
    } t_dec;

endpackage

// ===== rtl/utfw_cell.sv =====
module utfw_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  utfw_pkg::t_probe i_probe,
    output utfw_pkg::t_probe o_probe
);
    import utfw_pkg::*;

    logic [CODE_W-1:0] r_codes [CELL_SLOTS];
    logic [ADV_W-1:0]  r_advs  [CELL_SLOTS];
    t_probe            r_probe;
    t_probe            n_probe;
    logic              local_slot;
    logic              wr_en;
    logic              hit;
    logic [ADV_W-1:0]  hit_adv;

    // A load whose remaining count falls inside this cell is written here (a search
    // checks the slots below it); otherwise the count drops by one cell's worth and it moves on.
    always_comb begin
        local_slot = i_probe.left < LEFT_W'(CELL_SLOTS);
        wr_en      = i_probe.valid && i_probe.is_load && !i_probe.found && local_slot;
        hit        = 1'b0;
        hit_adv    = '0;
        for (int k = 0; k < CELL_SLOTS; k++) begin
            if (!hit && !i_probe.is_load && !i_probe.found &&
                (LEFT_W'(k) < i_probe.left) && (r_codes[k] == i_probe.code)) begin
                hit     = 1'b1;
                hit_adv = r_advs[k];
            end
        end
        n_probe      = i_probe;
        n_probe.left = local_slot ? '0 : i_probe.left - LEFT_W'(CELL_SLOTS);
        if (wr_en) begin
            n_probe.found = 1'b1;
        end
        if (hit) begin
            n_probe.found = 1'b1;
            n_probe.adv   = hit_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_codes[i_probe.left[CELL_SEL_W-1:0]] <= i_probe.code;
            r_advs[i_probe.left[CELL_SEL_W-1:0]]  <= i_probe.adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe.valid <= n_probe.valid;
        end
        r_probe.is_load <= n_probe.is_load;
        r_probe.found   <= n_probe.found;
        r_probe.left    <= n_probe.left;
        r_probe.code    <= n_probe.code;
        r_probe.adv     <= n_probe.adv;
    end

    assign o_probe = r_probe;

endmodule

// ===== rtl/utfw_decode.sv =====
module utfw_decode (
    input  logic [utfw_pkg::BYTE_W-1:0] i_byte,
    input  logic [utfw_pkg::PEND_W-1:0] i_pending,
    input  logic [utfw_pkg::CODE_W-1:0] i_partial,
    output utfw_pkg::t_dec              o_dec
);
    import utfw_pkg::*;

    logic [CODE_W-1:0] merged;

    always_comb begin
        merged  = {i_partial[CODE_W-7:0], i_byte[5:0] & UTF_BITS_CONT[5:0]};
        o_dec   = '0;
        if (i_pending == '0) begin
            if (i_byte < UTF_ASCII_LIM) begin
                o_dec.done = 1'b1;
                o_dec.cp   = CODE_W'(i_byte);
            end else if ((i_byte & UTF_MASK_2) == UTF_LEAD_2) begin
                o_dec.partial = CODE_W'(i_byte & UTF_BITS_2);
                o_dec.pending = PEND_W'(1);
            end else if ((i_byte & UTF_MASK_3) == UTF_LEAD_3) begin
                o_dec.partial = CODE_W'(i_byte & UTF_BITS_3);
                o_dec.pending = PEND_W'(2);
            end else if ((i_byte & UTF_MASK_4) == UTF_LEAD_4) begin
                o_dec.partial = CODE_W'(i_byte & UTF_BITS_4);
                o_dec.pending = PEND_W'(3);
            end else begin
                o_dec.done = 1'b1;
                o_dec.cp   = CP_QMARK;
            end
        end else begin
            o_dec.pending = i_pending - PEND_W'(1);
            if (i_pending == PEND_W'(1)) begin
                o_dec.done = 1'b1;
                o_dec.cp   = merged;
            end else begin
                o_dec.partial = merged;
            end
        end
    end

endmodule

// ===== rtl/utf8_text_width_measure.sv =====
// Channel  | Direction | Handshake                 | Payload
// input    | in        | i_in_valid / o_in_ready   | i_in_item  (utfw_pkg::t_in_item)
// output   | out       | o_out_valid / i_out_ready | o_out_item (utfw_pkg::t_out_item)
// config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A load item, and a text byte that neither completes a codepoint nor ends the string, leave the controller idle.
// A completed codepoint walks the row of CELLS lookup cells, one cell per cycle,
// and the input waits in S_WALK until it leaves the row.
// A string end moves the result into the output register through S_FIN.
// Reset is synchronous and active low; the glyph table holds no reset value.
// A full output register stalls input only when a second result is due.
module utf8_text_width_measure (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  utfw_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output utfw_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [utfw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [utfw_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import utfw_pkg::*;

`include "utf8_text_width_measure_defines.svh"

    // Controller states: waiting for an item, waiting for a lookup to leave
    // the cell row, and handing a finished width to the output register.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [GCOUNT_W-1:0] r_gcount;
    logic [CELLW_W-1:0]  r_cellw;
    logic [PEND_W-1:0]   r_pending, n_pending;
    logic [CODE_W-1:0]   r_partial, n_partial;
    logic [WIDTH_W-1:0]  r_sum, n_sum;
    logic                r_skip, n_skip;
    logic                r_last, n_last;
    logic                r_zero, n_zero;
    t_probe              r_probe, n_probe;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    t_dec                dec;
    t_probe              link [CELLS+1];
    logic                in_acc;
    logic                out_free;
    logic                walk_done;
    logic [ADV_W-1:0]    step_adv;
    logic [WIDTH_W:0]    sum_ext;
    logic [LEFT_W-1:0]   search_left;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_out_ready;

    utfw_decode u_decode (
        .i_byte    (i_in_item.text_byte),
        .i_pending (r_pending),
        .i_partial (r_partial),
        .o_dec     (dec)
    );

    // The lookup row: each cell owns CELL_SLOTS table slots and passes the
    // probe to its neighbor every cycle.
    assign link[0] = r_probe;
    for (genvar c = 0; c < CELLS; c++) begin : g_cell
        utfw_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_probe (link[c]),
            .o_probe (link[c+1])
        );
    end

    assign walk_done = link[CELLS].valid && !link[CELLS].is_load;

    // Only slots below glyph_count are searched, never more than the table has.
    assign search_left = (CMP_W'(r_gcount) > CMP_W'(GLYPH_SLOTS)) ?
                         LEFT_W'(GLYPH_SLOTS) : LEFT_W'(r_gcount);

    // Unknown codepoints advance by half a cell, rounded down.
    assign step_adv = link[CELLS].found ? link[CELLS].adv : (r_cellw >> 1);
    assign sum_ext  = {1'b0, r_sum} + (WIDTH_W + 1)'(step_adv);

    always_comb begin
        n_state     = r_state;
        n_pending   = r_pending;
        n_partial   = r_partial;
        n_sum       = r_sum;
        n_skip      = r_skip;
        n_last      = r_last;
        n_zero      = r_zero;
        n_probe     = r_probe;
        n_probe.valid = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in_item.op == OP_LOAD)) begin
                    // Slot writes ride the same row, ahead of any later search.
                    if (CMP_W'(i_in_item.slot) < CMP_W'(GLYPH_SLOTS)) begin
                        n_probe.valid   = 1'b1;
                        n_probe.is_load = 1'b1;
                        n_probe.found   = 1'b0;
                        n_probe.left    = LEFT_W'(i_in_item.slot);
                        n_probe.code    = i_in_item.glyph_code;
                        n_probe.adv     = i_in_item.glyph_advance;
                    end
                end else if (in_acc && r_skip) begin
                    // Bytes after a decoded zero are dropped up to the last one.
                    if (i_in_item.last) begin
                        n_skip = 1'b0;
                    end
                end else if (in_acc) begin
                    n_last    = i_in_item.last;
                    n_pending = dec.pending;
                    n_partial = dec.partial;
                    if (dec.done && (dec.cp == '0)) begin
                        n_zero    = 1'b1;
                        n_skip    = !i_in_item.last;
                        n_pending = '0;
                        n_partial = '0;
                        n_state   = S_FIN;
                    end else if (dec.done) begin
                        n_probe.valid   = 1'b1;
                        n_probe.is_load = 1'b0;
                        n_probe.found   = 1'b0;
                        n_probe.left    = search_left;
                        n_probe.code    = dec.cp;
                        n_probe.adv     = '0;
                        n_state         = S_WALK;
                    end else if (i_in_item.last) begin
                        // A sequence cut short by the last byte adds nothing.
                        n_zero    = 1'b0;
                        n_pending = '0;
                        n_partial = '0;
                        n_state   = S_FIN;
                    end
                end
            end
            S_WALK: begin
                if (walk_done) begin
                    n_sum = sum_ext[WIDTH_W] ? WIDTH_MAX : sum_ext[WIDTH_W-1:0];
                    if (r_last) begin
                        n_zero  = 1'b0;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.total_width   = r_sum;
                    n_out.ended_by_zero = r_zero;
                    n_sum               = '0;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_gcount      <= '0;
            r_cellw       <= CELLW_W'(16);
            r_pending     <= '0;
            r_partial     <= '0;
            r_sum         <= '0;
            r_skip        <= 1'b0;
            r_probe.valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_pending     <= n_pending;
            r_partial     <= n_partial;
            r_sum         <= n_sum;
            r_skip        <= n_skip;
            r_probe.valid <= n_probe.valid;
            r_out_valid   <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_GLYPH_COUNT: r_gcount <= i_cfg_data[GCOUNT_W-1:0];
                    REG_CELL_WIDTH:  r_cellw  <= i_cfg_data[CELLW_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        r_probe.is_load <= n_probe.is_load;
        r_probe.found   <= n_probe.found;
        r_probe.left    <= n_probe.left;
        r_probe.code    <= n_probe.code;
        r_probe.adv     <= n_probe.adv;
    end

    always_ff @(posedge i_clk) begin
        r_last          <= n_last;
        r_zero          <= n_zero;
        r_out           <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // A search leaves the row only while the controller waits for it.
    `UTFW_ASSERT_NOW(a_walk_only, i_clk, i_rst_n, walk_done, r_state == S_WALK, "search left row outside walk")
    // While skipping to the end of a string, no decode state is left over.
    `UTFW_ASSERT_NOW(a_skip_clean, i_clk, i_rst_n, r_skip && (r_state == S_IDLE), (r_pending == '0) && (r_sum == '0), "skip with live decode state")
    // A skipped text byte never starts a lookup or a result.
    `UTFW_ASSERT_NEXT(a_skip_quiet, i_clk, i_rst_n, in_acc && (i_in_item.op == OP_TEXT) && r_skip, (r_state == S_IDLE) && !r_probe.valid, "skipped byte caused work")
    // A finished width reaches the output register as soon as it is free.
    `UTFW_ASSERT_NEXT(a_fin_out, i_clk, i_rst_n, (r_state == S_FIN) && out_free, o_out_valid && (r_state == S_IDLE) && (r_sum == '0), "result not delivered")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import utfw_pkg::*;

    // Cycles to let pass after the last result before a register write or the
    // end of the run. A codepoint walks the whole cell row before it lands, and
    // a load or a partial sequence gives no result, so this covers the longest
    // trip through the block with some margin.
    localparam int SETTLE_CYCLES = CELLS + 16;
    // Cycles in a row with no item moving on any channel before the run is
    // declared hung. Far above one lookup plus a long receiver stall.
    localparam int STALL_LIMIT = 4000;
    // Percentage of cycles in which each side idles.
    localparam int IDLE_PCT = 21;
    // Text items per random phase; with the table fill, seven phases give
    // about 1500 items in all.
    localparam int TEXTS_PER_PHASE = 165;
    localparam int ALPHA_N = 32;

    // Register indexes the block does not define; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // When set, neither side idles; used for one long stretch of full-rate traffic.
    logic no_idle = 1'b0;

    // Items waiting to be driven, register writes waiting to be driven, and the
    // widths the block owes us, oldest first.
    t_in_item                        item_feed[$];
    logic [CFG_IDX_W+CFG_DATA_W-1:0] reg_writes[$];
    t_out_item                       expected_widths[$];

    int fail_count = 0;
    int quiet_cycles = 0;
    int texts_sent = 0;

    // Our own copy of the block's state: glyph table, decoder, running sum and
    // the two registers.
    logic [CODE_W-1:0]   glyph_codes[GLYPH_SLOTS];
    logic [ADV_W-1:0]    glyph_advs[GLYPH_SLOTS];
    logic [PEND_W-1:0]   dec_pending = '0;
    logic [CODE_W-1:0]   dec_partial = '0;
    logic [WIDTH_W-1:0]  run_width = '0;
    logic                skip_rest = 1'b0;
    logic [GCOUNT_W-1:0] glyph_count = '0;
    logic [CELLW_W-1:0]  cell_width = 8'd16;

    // Codepoints that strings are mostly built from, so that lookups hit often.
    logic [CODE_W-1:0] alphabet[ALPHA_N];
    // Bytes of the string under construction.
    logic [BYTE_W-1:0] str_bytes[$];

    utf8_text_width_measure uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Width predictor
    // ------------------------------------------------------------------

    // Every end of a string puts the decoder and the sum back to zero.
    task automatic restart_string();
        dec_pending = '0;
        dec_partial = '0;
        run_width   = '0;
    endtask

    // Takes one accepted item and queues the width it causes, if any.
    task automatic measure_byte(input t_in_item it);
        logic [CODE_W-1:0]  cp;
        logic               done;
        logic               hit;
        logic [ADV_W-1:0]   adv;
        logic [WIDTH_W:0]   sum;
        int                 n;
        t_out_item          res;
        cp   = '0;
        done = 1'b0;

        // A load only writes the table; the decoder keeps its place.
        if (it.op == OP_LOAD) begin
            glyph_codes[it.slot] = it.glyph_code;
            glyph_advs[it.slot]  = it.glyph_advance;
            return;
        end

        // After a zero codepoint everything up to the last byte is dropped.
        if (skip_rest) begin
            if (it.last) begin
                skip_rest = 1'b0;
                restart_string();
            end
            return;
        end

        if (dec_pending == 0) begin
            if (it.text_byte < UTF_ASCII_LIM) begin
                cp   = {{(CODE_W-BYTE_W){1'b0}}, it.text_byte};
                done = 1'b1;
            end else if ((it.text_byte & UTF_MASK_2) == UTF_LEAD_2) begin
                dec_partial = {{(CODE_W-BYTE_W){1'b0}}, it.text_byte & UTF_BITS_2};
                dec_pending = 2'd1;
            end else if ((it.text_byte & UTF_MASK_3) == UTF_LEAD_3) begin
                dec_partial = {{(CODE_W-BYTE_W){1'b0}}, it.text_byte & UTF_BITS_3};
                dec_pending = 2'd2;
            end else if ((it.text_byte & UTF_MASK_4) == UTF_LEAD_4) begin
                dec_partial = {{(CODE_W-BYTE_W){1'b0}}, it.text_byte & UTF_BITS_4};
                dec_pending = 2'd3;
            end else begin
                // Not a lead byte at all: it stands for a question mark.
                cp   = CP_QMARK;
                done = 1'b1;
            end
        end else begin
            // Continuation bits are taken as they come, without a check.
            dec_partial = {dec_partial[CODE_W-7:0], it.text_byte[5:0]};
            dec_pending = dec_pending - 2'd1;
            if (dec_pending == 0) begin
                cp          = dec_partial;
                dec_partial = '0;
                done        = 1'b1;
            end
        end

        if (done) begin
            if (cp == 0) begin
                if (!it.last) begin
                    skip_rest = 1'b1;
                end
                res.total_width   = run_width;
                res.ended_by_zero = 1'b1;
                expected_widths.push_back(res);
                restart_string();
                return;
            end
            // The lowest matching slot in the searched range wins.
            n   = (glyph_count > GLYPH_SLOTS) ? GLYPH_SLOTS : int'(glyph_count);
            hit = 1'b0;
            adv = cell_width >> 1;
            for (int i = 0; i < n; i++) begin
                if (!hit && glyph_codes[i] == cp) begin
                    hit = 1'b1;
                    adv = glyph_advs[i];
                end
            end
            sum       = {1'b0, run_width} + adv;
            run_width = (sum > WIDTH_MAX) ? WIDTH_MAX : sum[WIDTH_W-1:0];
        end

        // The last byte closes the string; an unfinished sequence adds nothing.
        if (it.last) begin
            res.total_width   = run_width;
            res.ended_by_zero = 1'b0;
            expected_widths.push_back(res);
            restart_string();
        end
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        if (idx == REG_GLYPH_COUNT) begin
            glyph_count = data;
        end else if (idx == REG_CELL_WIDTH) begin
            cell_width = data[CELLW_W-1:0];
        end
    endtask

    task automatic check_width(input t_out_item got);
        t_out_item want;
        if (expected_widths.size() == 0) begin
            $error("unexpected item: total_width %0d ended_by_zero %0b",
                   got.total_width, got.ended_by_zero);
            fail_count++;
        end else begin
            want = expected_widths.pop_front();
            if (got.total_width !== want.total_width) begin
                $error("total_width: expected %0d, actual %0d",
                       want.total_width, got.total_width);
                fail_count++;
            end
            if (got.ended_by_zero !== want.ended_by_zero) begin
                $error("ended_by_zero: expected %0b, actual %0b",
                       want.ended_by_zero, got.ended_by_zero);
                fail_count++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver, monitor, register writer and watchdog
    // ------------------------------------------------------------------

    // Input driver. An item is predicted at the edge where it is accepted.
    // Valid is only lowered or reloaded when the current item has gone.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                measure_byte(in_item);
            end
            if (!in_valid || in_ready) begin
                if (item_feed.size() > 0 &&
                    (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    in_valid <= 1'b1;
                    in_item  <= item_feed.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Ready wanders at random outside the full-rate stretch, so stalls hit the other phases.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                check_width(out_item);
            end
            out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Register writer. The copy of the registers follows the accepted writes.
    always @(posedge clk) begin
        if (!rst_n) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                apply_reg(cfg_index, cfg_data);
            end
            if (!cfg_valid || cfg_ready) begin
                if (reg_writes.size() > 0) begin
                    cfg_valid              <= 1'b1;
                    {cfg_index, cfg_data}  <= reg_writes.pop_front();
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Watchdog: the run is over if no item moves on any channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // A text item; the load fields carry random bits the block must ignore.
    task automatic push_text(input logic [BYTE_W-1:0] b, input logic is_last);
        t_in_item it;
        it.op            = OP_TEXT;
        it.slot          = SLOT_W'($urandom());
        it.glyph_code    = CODE_W'($urandom());
        it.glyph_advance = ADV_W'($urandom());
        it.text_byte     = b;
        it.last          = is_last;
        item_feed.push_back(it);
        texts_sent++;
    endtask

    // A load item; the text fields carry random bits the block must ignore.
    task automatic push_load(input logic [SLOT_W-1:0] s, input logic [CODE_W-1:0] code,
                             input logic [ADV_W-1:0] adv);
        t_in_item it;
        it.op            = OP_LOAD;
        it.slot          = s;
        it.glyph_code    = code;
        it.glyph_advance = adv;
        it.text_byte     = BYTE_W'($urandom());
        it.last          = 1'($urandom());
        item_feed.push_back(it);
    endtask

    // Mostly codepoints of the alphabet, some plain ASCII, some anything at all.
    function automatic logic [CODE_W-1:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return alphabet[$urandom_range(0, ALPHA_N - 1)];
        end else if (r < 85) begin
            return CODE_W'($urandom_range(1, 127));
        end
        return CODE_W'($urandom());
    endfunction

    // Appends the shortest UTF-8 form of a codepoint to the string.
    task automatic add_cp(input logic [CODE_W-1:0] cp);
        if (cp < 'h80) begin
            str_bytes.push_back(cp[7:0]);
        end else if (cp < 'h800) begin
            str_bytes.push_back({3'b110, cp[10:6]});
            str_bytes.push_back({2'b10, cp[5:0]});
        end else if (cp < 'h10000) begin
            str_bytes.push_back({4'b1110, cp[15:12]});
            str_bytes.push_back({2'b10, cp[11:6]});
            str_bytes.push_back({2'b10, cp[5:0]});
        end else begin
            str_bytes.push_back({5'b11110, cp[20:18]});
            str_bytes.push_back({2'b10, cp[17:12]});
            str_bytes.push_back({2'b10, cp[11:6]});
            str_bytes.push_back({2'b10, cp[5:0]});
        end
    endtask

    // Sends the built string, marking its final byte, with the odd table load
    // slipped in between bytes.
    task automatic send_string();
        for (int i = 0; i < str_bytes.size(); i++) begin
            if ($urandom_range(0, 99) < 4) begin
                push_load(SLOT_W'($urandom()), pick_code(), ADV_W'($urandom()));
            end
            push_text(str_bytes[i], i == str_bytes.size() - 1);
        end
        str_bytes.delete();
    endtask

    // Waits until every item is in, every width is out, and the block has had
    // time to finish any lookup that gives no result.
    task automatic settle();
        while (item_feed.size() != 0 || in_valid) @(negedge clk);
        while (expected_widths.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes both registers while the block is idle. Cell width data carries a
    // random ninth bit, which the register drops.
    task automatic set_regs(input logic [GCOUNT_W-1:0] gc, input logic [CELLW_W-1:0] cw,
                            input logic with_spare);
        settle();
        reg_writes.push_back({REG_CELL_WIDTH, 1'($urandom()), cw});
        reg_writes.push_back({REG_GLYPH_COUNT, gc});
        if (with_spare) begin
            reg_writes.push_back({REG_SPARE_2, CFG_DATA_W'($urandom())});
            reg_writes.push_back({REG_SPARE_3, CFG_DATA_W'($urandom())});
        end
        while (reg_writes.size() != 0 || cfg_valid) @(negedge clk);
    endtask

    // Random strings: most are well formed, some end in a cut-off sequence,
    // and the rest are noise full of stray, invalid and zero bytes.
    task automatic run_phase(input int n_text);
        int kind;
        int len;
        int lead_len;
        texts_sent = 0;
        while (texts_sent < n_text) begin
            kind = $urandom_range(0, 99);
            len  = $urandom_range(1, 10);
            if (kind < 70) begin
                repeat (len) add_cp(pick_code());
            end else if (kind < 85) begin
                repeat (len - 1) add_cp(pick_code());
                // A lead byte with fewer continuations than it asks for.
                lead_len = $urandom_range(2, 4);
                if (lead_len == 2) begin
                    str_bytes.push_back(8'($urandom_range('hC0, 'hDF)));
                end else if (lead_len == 3) begin
                    str_bytes.push_back(8'($urandom_range('hE0, 'hEF)));
                end else begin
                    str_bytes.push_back(8'($urandom_range('hF0, 'hF7)));
                end
                repeat ($urandom_range(0, lead_len - 2)) begin
                    str_bytes.push_back(8'($urandom_range('h80, 'hBF)));
                end
            end else begin
                repeat (len) begin
                    case ($urandom_range(0, 5))
                        0: str_bytes.push_back(8'($urandom()));
                        1: str_bytes.push_back(8'($urandom_range('h80, 'hBF)));
                        2: str_bytes.push_back(8'($urandom_range('hF8, 'hFF)));
                        3: str_bytes.push_back(8'h00);
                        4: begin
                            // Overlong forms of zero also end the string.
                            str_bytes.push_back(8'hC0);
                            str_bytes.push_back(8'h80);
                        end
                        default: str_bytes.push_back(8'($urandom_range('hC0, 'hF7)));
                    endcase
                end
            end
            send_string();
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < ALPHA_N; i++) begin
            case (i % 4)
                0: alphabet[i] = CODE_W'($urandom_range('h21, 'h7E));
                1: alphabet[i] = CODE_W'($urandom_range('h80, 'h7FF));
                2: alphabet[i] = CODE_W'($urandom_range('h800, 'hFFFF));
                default: alphabet[i] = CODE_W'($urandom_range('h10000, 'h1FFFFF));
            endcase
        end

        // Directed strings with the reset registers: no slot is searched, so
        // every codepoint costs half of the cell width.
        push_text("A", 1'b1);
        push_text(8'h00, 1'b1);             // zero on the last byte: one item only
        push_text("a", 1'b0);
        push_text(8'h00, 1'b0);             // zero ends the string early
        push_text("b", 1'b0);               // ignored up to the last byte
        push_text(8'hFF, 1'b0);
        push_text("c", 1'b1);
        push_text(8'hFF, 1'b1);             // invalid lead byte
        push_text(8'h80, 1'b0);             // stray continuation as a lead
        push_text(8'hF8, 1'b1);
        push_text(8'hC0, 1'b0);             // overlong zero on the last byte
        push_text(8'h80, 1'b1);
        push_text(8'hE2, 1'b0);             // a load in mid-sequence
        push_load(8'd5, 21'h0020AC, 8'd3);
        push_text(8'h82, 1'b0);
        push_text(8'hAC, 1'b1);
        push_text(8'hF7, 1'b0);             // largest four-byte codepoint
        push_text(8'hBF, 1'b0);
        push_text(8'hBF, 1'b0);
        push_text(8'hBF, 1'b1);
        push_text("x", 1'b0);               // sequence cut short by the last byte
        push_text(8'hE2, 1'b0);
        push_text(8'h82, 1'b1);
        push_text(8'h7F, 1'b0);
        push_text(8'hE0, 1'b0);             // overlong zero ends the string early
        push_text(8'h80, 1'b0);
        push_text(8'h80, 1'b0);
        push_text("!", 1'b1);

        // Fill every slot before any lookup can reach the table, with the
        // extreme codepoint and advances among the entries.
        set_regs(9'd0, 8'd255, 1'b0);
        for (int s = 0; s < GLYPH_SLOTS; s++) begin
            if (s == 3) begin
                push_load(SLOT_W'(s), 21'h1FFFFF, 8'd200);
            end else if (s == 7) begin
                push_load(SLOT_W'(s), pick_code(), 8'd0);
            end else if (s == 9) begin
                push_load(SLOT_W'(s), pick_code(), 8'd255);
            end else begin
                push_load(SLOT_W'(s), pick_code(), ADV_W'($urandom()));
            end
        end

        set_regs(9'd256, 8'd0, 1'b0);
        run_phase(TEXTS_PER_PHASE);

        set_regs(9'd1, 8'd255, 1'b0);
        run_phase(TEXTS_PER_PHASE);

        // A count beyond the table searches the whole table and no further.
        set_regs(9'd511, 8'd7, 1'b0);
        run_phase(TEXTS_PER_PHASE);

        set_regs(9'd300, 8'd200, 1'b1);
        run_phase(TEXTS_PER_PHASE);

        set_regs(9'd0, 8'd1, 1'b0);
        run_phase(TEXTS_PER_PHASE);

        // A long stretch at full rate on both sides.
        set_regs(9'd37, CELLW_W'($urandom()), 1'b0);
        no_idle = 1'b1;
        run_phase(TEXTS_PER_PHASE);
        settle();
        no_idle = 1'b0;

        // The whole table searched once more with a random cell width.
        set_regs(9'd256, CELLW_W'($urandom()), 1'b0);
        run_phase(TEXTS_PER_PHASE);

        settle();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
